// ----- rtl/sdiv_pkg.sv -----
// ============================================================================
// sdiv_pkg - shared types and constants for the saturating s16 divide
// Widths, the work item that travels down the divide pipeline, and the
// saturation / substitute codes used by the output stage.
// ============================================================================
`default_nettype none

package sdiv_pkg;

    // operand and result width
    localparam int SDIV_WIDTH = 16;

    // quotient bits resolved in each divide stage (default)
    localparam int SDIV_BITS_PER_STAGE = 4;

    // saturation and substitute values
    localparam logic [SDIV_WIDTH-1:0] SDIV_Q_MAX  = 16'h7FFF;
    localparam logic [SDIV_WIDTH-1:0] SDIV_Q_MIN  = 16'h8000;
    localparam logic [SDIV_WIDTH-1:0] SDIV_Q_ZERO = 16'h0000;

    // sign and special-case flags carried alongside the magnitudes
    typedef struct packed {
        logic neg_q;     // quotient sign (dividend sign xor divisor sign)
        logic zero_div;  // divisor was zero
        logic num_neg;   // dividend was negative
        logic num_zero;  // dividend was zero
    } t_sdiv_flags;

    // partial divide state: remainder, shifting dividend/quotient, divisor
    typedef struct packed {
        logic [SDIV_WIDTH-1:0] rem;
        logic [SDIV_WIDTH-1:0] quo;
        logic [SDIV_WIDTH-1:0] den;
        t_sdiv_flags           flags;
    } t_sdiv_work;

endpackage : sdiv_pkg

`default_nettype wire

// ----- rtl/sdiv_prep.sv -----
// ============================================================================
// sdiv_prep - operand preparation stage
// Registers the magnitudes of both operands together with the sign and
// zero flags that the output stage needs.
// ============================================================================
`default_nettype none

module sdiv_prep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [sdiv_pkg::SDIV_WIDTH-1:0] i_dividend,
    input  logic signed [sdiv_pkg::SDIV_WIDTH-1:0] i_divisor,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output sdiv_pkg::t_sdiv_work                 o_data
);
    import sdiv_pkg::*;

    logic                  r_valid;
    t_sdiv_work            r_data;
    t_sdiv_work            n_data;
    logic [SDIV_WIDTH-1:0] num_raw;
    logic [SDIV_WIDTH-1:0] den_raw;

    // stage can take an item when empty or when its item moves on
    assign o_ready = !r_valid || i_ready;

    // magnitudes and flags
    always_comb begin
        num_raw = $unsigned(i_dividend);
        den_raw = $unsigned(i_divisor);
        n_data.flags.num_neg  = num_raw[SDIV_WIDTH-1];
        n_data.flags.num_zero = (num_raw == '0);
        n_data.flags.zero_div = (den_raw == '0);
        n_data.flags.neg_q    = num_raw[SDIV_WIDTH-1] ^ den_raw[SDIV_WIDTH-1];
        n_data.rem = '0;
        n_data.quo = num_raw[SDIV_WIDTH-1] ? (~num_raw + 1'b1) : num_raw;
        n_data.den = den_raw[SDIV_WIDTH-1] ? (~den_raw + 1'b1) : den_raw;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule : sdiv_prep

`default_nettype wire

// ----- rtl/sdiv_step.sv -----
// ============================================================================
// sdiv_step - one restoring divide stage
// Resolves P_BITS quotient bits of the unsigned magnitudes per stage and
// registers the partial remainder and quotient.
// ============================================================================
`default_nettype none

module sdiv_step #(
    parameter int P_BITS = sdiv_pkg::SDIV_BITS_PER_STAGE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sdiv_pkg::t_sdiv_work i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sdiv_pkg::t_sdiv_work o_data
);
    import sdiv_pkg::*;

    logic                r_valid;
    t_sdiv_work          r_data;
    t_sdiv_work          n_data;
    logic [SDIV_WIDTH:0] part;
    logic [SDIV_WIDTH:0] diff;

    assign o_ready = !r_valid || i_ready;

    // shift in the next dividend bit, trial subtract, keep or restore
    always_comb begin
        n_data = i_data;
        part   = '0;
        diff   = '0;
        for (int k = 0; k < P_BITS; k++) begin
            part = {n_data.rem, n_data.quo[SDIV_WIDTH-1]};
            diff = part - {1'b0, n_data.den};
            if (!diff[SDIV_WIDTH]) begin
                n_data.rem = diff[SDIV_WIDTH-1:0];
                n_data.quo = {n_data.quo[SDIV_WIDTH-2:0], 1'b1};
            end else begin
                n_data.rem = part[SDIV_WIDTH-1:0];
                n_data.quo = {n_data.quo[SDIV_WIDTH-2:0], 1'b0};
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule : sdiv_step

`default_nettype wire

// ----- rtl/sdiv_fix.sv -----
// ============================================================================
// sdiv_fix - sign, saturation and zero-divisor output stage
// Applies the quotient sign, clamps the one overflowing case and picks
// the substitute value for a zero divisor, then holds the result item.
// ============================================================================
`default_nettype none

module sdiv_fix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  sdiv_pkg::t_sdiv_work                 i_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [sdiv_pkg::SDIV_WIDTH-1:0] o_quotient,
    output logic                                 o_zero_divisor
);
    import sdiv_pkg::*;

    logic                  r_valid;
    logic [SDIV_WIDTH-1:0] r_quotient;
    logic                  r_zero_divisor;
    logic [SDIV_WIDTH-1:0] n_quotient;
    logic [SDIV_WIDTH-1:0] mag;

    assign o_ready = !r_valid || i_ready;

    // final quotient selection
    always_comb begin
        mag = i_data.quo;
        priority if (i_data.flags.zero_div) begin
            priority if (i_data.flags.num_zero) begin
                n_quotient = SDIV_Q_ZERO;
            end else if (i_data.flags.num_neg) begin
                n_quotient = SDIV_Q_MIN;
            end else begin
                n_quotient = SDIV_Q_MAX;
            end
        end else if (i_data.flags.neg_q) begin
            // a magnitude of 32768 negates to the minimum value itself
            n_quotient = ~mag + 1'b1;
        end else if (mag[SDIV_WIDTH-1]) begin
            // minimum value divided by minus one
            n_quotient = SDIV_Q_MAX;
        end else begin
            n_quotient = mag;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_quotient     <= n_quotient;
            r_zero_divisor <= i_data.flags.zero_div;
        end
    end

    assign o_valid        = r_valid;
    assign o_quotient     = $signed(r_quotient);
    assign o_zero_divisor = r_zero_divisor;

endmodule : sdiv_fix

`default_nettype wire

// ----- rtl/saturating_s16_pixel_divide_unit.sv -----
// ============================================================================
// saturating_s16_pixel_divide_unit - pipelined saturating s16 divide
// Signed 16-bit divide with truncation toward zero, saturation and a
// zero-divisor flag, built as a restoring divider split over stages.
// ============================================================================
// The unit takes one dividend/divisor item per cycle while the output side
// takes results, and returns one result item per input, in order. It has
// one operand stage, the restoring divide stages, each resolving
// P_BITS_PER_STAGE quotient bits, and one output stage. Throughput is one
// item per cycle whenever the output side takes results; every stage has
// its own valid bit and holds its item under backpressure, so bubbles are
// squeezed out while the output is stalled.
// P_BITS_PER_STAGE must divide 16 (1, 2, 4 or 8). A zero divisor gives
// 0, -32768 or 32767 by dividend sign and raises o_zero_divisor;
// -32768 / -1 saturates to 32767.
`default_nettype none

module saturating_s16_pixel_divide_unit #(
    parameter int P_BITS_PER_STAGE = sdiv_pkg::SDIV_BITS_PER_STAGE
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [sdiv_pkg::SDIV_WIDTH-1:0] i_dividend,
    input  logic signed [sdiv_pkg::SDIV_WIDTH-1:0] i_divisor,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [sdiv_pkg::SDIV_WIDTH-1:0] o_quotient,
    output logic                                 o_zero_divisor
);
    import sdiv_pkg::*;

    localparam int STAGES = SDIV_WIDTH / P_BITS_PER_STAGE;

    t_sdiv_work w_data  [0:STAGES];
    logic       w_valid [0:STAGES];
    logic       w_ready [0:STAGES];

    // operand magnitudes and flags
    sdiv_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_data     (w_data[0])
    );

    // divide stages
    for (genvar s = 0; s < STAGES; s++) begin : g_step
        sdiv_step #(
            .P_BITS (P_BITS_PER_STAGE)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[s]),
            .o_ready (w_ready[s]),
            .i_data  (w_data[s]),
            .o_valid (w_valid[s+1]),
            .i_ready (w_ready[s+1]),
            .o_data  (w_data[s+1])
        );
    end

    // sign, saturation and result register
    sdiv_fix u_fix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_valid[STAGES]),
        .o_ready        (w_ready[STAGES]),
        .i_data         (w_data[STAGES]),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_quotient     (o_quotient),
        .o_zero_divisor (o_zero_divisor)
    );

endmodule : saturating_s16_pixel_divide_unit

`default_nettype wire

// ----- rtl/sdiv_checker.sv -----
// ============================================================================
// sdiv_checker - port-level checks for the saturating s16 divide
// Watches the top-level ports for handshake holding, reset behavior,
// backpressure origin and legal zero-divisor substitutes.
// ============================================================================
`default_nettype none

module sdiv_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_ready,
    input  logic signed [sdiv_pkg::SDIV_WIDTH-1:0] i_dividend,
    input  logic signed [sdiv_pkg::SDIV_WIDTH-1:0] i_divisor,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic signed [sdiv_pkg::SDIV_WIDTH-1:0] o_quotient,
    input  logic                                 o_zero_divisor
);
    import sdiv_pkg::*;

    // a stalled result item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quotient) && $stable(o_zero_divisor))
        else $error("result item changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input side only backs up when the output is stalled
    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input not ready without output backpressure");

    // zero divisor gives only a substitute value
    a_zero_subst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_divisor |->
            ($unsigned(o_quotient) == SDIV_Q_ZERO) ||
            ($unsigned(o_quotient) == SDIV_Q_MIN) ||
            ($unsigned(o_quotient) == SDIV_Q_MAX))
        else $error("bad zero-divisor substitute");

    // a waiting input item stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_dividend) && $stable(i_divisor))
        else $error("input item changed while waiting");

endmodule : sdiv_checker

bind saturating_s16_pixel_divide_unit sdiv_checker u_sdiv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_dividend     (i_dividend),
    .i_divisor      (i_divisor),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_quotient     (o_quotient),
    .o_zero_divisor (o_zero_divisor)
);

`default_nettype wire
